>>> design/psm_pkg.sv
// Shared types and constants for the schoolbook polynomial multiplier.
`default_nettype none

package psm_pkg;

  localparam int COEF_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int ACC_W  = 36;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // operand_select codes
  localparam logic OPS_A = 1'b0;
  localparam logic OPS_B = 1'b1;

  typedef struct packed {
    logic  operand_select;
    coef_t coefficient;
    logic  last_term;
  } in_item_t;

  typedef struct packed {
    acc_t product_coefficient;
    logic last_result;
  } out_item_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic clr;    // drop everything: accumulators and stored A
    logic inval;  // drop stored A only
    logic mac;    // accumulate and shift A slots one cell up
    logic drain;  // shift accumulators one cell down
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/psm_cell.sv
// One multiply-accumulate cell: an A slot that shifts up and an accumulator that drains down.
`default_nettype none

module psm_cell
  import psm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      wr_hit,
  input  wire coef_t     wr_coef,
  input  wire coef_t     b_coef,
  input  wire coef_t     slot_in,
  input  wire logic      slot_vld_in,
  input  wire acc_t      acc_in,
  output logic           slot_vld_out,
  output coef_t          slot_out,
  output acc_t           acc_out
);

  coef_t                    slot_r, slot_nxt;
  logic                     vld_r, vld_nxt;
  acc_t                     acc_r, acc_nxt;
  logic signed [PROD_W-1:0] raw_prod;
  logic signed [PROD_W-1:0] prod;

  // keep the multiply in a signed context of its own
  assign raw_prod = slot_r * b_coef;
  assign prod     = vld_r ? raw_prod : '0;

  always_comb begin
    slot_nxt = slot_r;
    vld_nxt  = vld_r;
    acc_nxt  = acc_r;
    if (ctl.mac) begin
      slot_nxt = slot_in;
      vld_nxt  = slot_vld_in;
      acc_nxt  = acc_r + ACC_W'(prod);
    end
    if (ctl.drain) begin
      acc_nxt = acc_in;
    end
    if (ctl.clr || ctl.inval) begin
      vld_nxt = 1'b0;
    end
    if (ctl.clr) begin
      acc_nxt = '0;
    end
    if (wr_hit) begin
      slot_nxt = wr_coef;
      vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign slot_vld_out = vld_r;
  assign slot_out     = slot_r;
  assign acc_out      = acc_r;

endmodule

`default_nettype wire

>>> design/polynomial_multiply_schoolbook.sv
// Top level of the schoolbook polynomial multiplier: sequencer and row of MAC cells.
`default_nettype none

// Timing: A and B coefficients are taken one per cycle while busy is low, and each B term
// is folded into all 2*MAX_TERMS-1 cells (one 16x16 multiplier each) in that same cycle.
// Once the last B term is taken, busy stays high while the accumulators drain down the
// cell row through cell 0: n = a_terms + b_terms - 1 product coefficients, one per
// cycle on out_item with out_strobe; last_result marks the final one. The next item is
// taken in the cycle after the final result. Results cannot be stalled. A terms beyond
// MAX_TERMS and B terms beyond MAX_TERMS are dropped, though their last_term mark counts.

module polynomial_multiply_schoolbook
  import psm_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output logic           busy,
  output logic           out_strobe,
  output out_item_t      out_item
);

  localparam int ACC_DEPTH = 2 * MAX_TERMS - 1;
  localparam int ALEN_W    = $clog2(MAX_TERMS + 1);
  localparam int CNT_W     = $clog2(ACC_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [ALEN_W-1:0] a_len_r, a_len_nxt;
  logic [ALEN_W-1:0] b_pos_r, b_pos_nxt;
  logic              loading_b_r, loading_b_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              accept;
  logic              a_wr;
  logic [ALEN_W-1:0] wr_idx;
  cell_ctl_t         ctl;

  logic  [ACC_DEPTH-1:0] wr_hit;
  logic  [ACC_DEPTH-1:0] slot_vld;
  coef_t [ACC_DEPTH-1:0] slot;
  acc_t  [ACC_DEPTH-1:0] acc;

  assign busy   = (state_r == ST_DRAIN);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    a_len_nxt     = a_len_r;
    b_pos_nxt     = b_pos_r;
    loading_b_nxt = loading_b_r;
    cnt_nxt       = cnt_r;
    ctl           = '0;
    a_wr          = 1'b0;
    wr_idx        = a_len_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (in_item.operand_select == OPS_A) begin
            // an A term after A was closed or B has begun drops the pending product
            if (loading_b_r) begin
              ctl.clr       = 1'b1;
              wr_idx        = '0;
              b_pos_nxt     = '0;
              loading_b_nxt = 1'b0;
            end
            a_len_nxt = wr_idx;
            if (wr_idx < ALEN_W'(MAX_TERMS)) begin
              a_wr      = 1'b1;
              a_len_nxt = wr_idx + 1'b1;
            end
            if (in_item.last_term) begin
              loading_b_nxt = 1'b1;
            end
          end else if (a_len_r != '0) begin
            loading_b_nxt = 1'b1;
            if (b_pos_r < ALEN_W'(MAX_TERMS)) begin
              ctl.mac   = 1'b1;
              b_pos_nxt = b_pos_r + 1'b1;
            end
            if (in_item.last_term) begin
              cnt_nxt       = CNT_W'(a_len_r) + CNT_W'(b_pos_nxt) - 1'b1;
              ctl.inval     = 1'b1;
              a_len_nxt     = '0;
              b_pos_nxt     = '0;
              loading_b_nxt = 1'b0;
              state_nxt     = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        ctl.drain = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      a_len_r     <= '0;
      b_pos_r     <= '0;
      loading_b_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      a_len_r     <= a_len_nxt;
      b_pos_r     <= b_pos_nxt;
      loading_b_r <= loading_b_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < ACC_DEPTH; k++) begin : g_cell
      coef_t s_in;
      logic  v_in;
      acc_t  a_in;

      if (k < MAX_TERMS) begin : g_wr
        assign wr_hit[k] = a_wr && (wr_idx == ALEN_W'(k));
      end else begin : g_nowr
        assign wr_hit[k] = 1'b0;
      end

      if (k == 0) begin : g_bot
        assign s_in = '0;
        assign v_in = 1'b0;
      end else begin : g_mid
        assign s_in = slot[k-1];
        assign v_in = slot_vld[k-1];
      end

      if (k == ACC_DEPTH - 1) begin : g_top
        assign a_in = '0;
      end else begin : g_low
        assign a_in = acc[k+1];
      end

      psm_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .wr_hit       (wr_hit[k]),
        .wr_coef      (in_item.coefficient),
        .b_coef       (in_item.coefficient),
        .slot_in      (s_in),
        .slot_vld_in  (v_in),
        .acc_in       (a_in),
        .slot_vld_out (slot_vld[k]),
        .slot_out     (slot[k]),
        .acc_out      (acc[k])
      );
    end
  endgenerate

  assign out_strobe                   = busy;
  assign out_item.product_coefficient = acc[0];
  assign out_item.last_result         = busy && (cnt_r == CNT_W'(1));

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cnt_r != '0)
    else $error("drain running with no results left");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last_result |=> !out_strobe)
    else $error("result after the final one");

  a_last_b_drains: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.operand_select == OPS_B && in_item.last_term && a_len_r != '0
    |=> busy && a_len_r == '0 && !loading_b_r)
    else $error("last B term did not start the drain");

  a_a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> slot_vld == '0)
    else $error("stored A survived into the drain");

endmodule

`default_nettype wire

>>> dv/polynomial_multiply_schoolbook_tb.sv
// Self-checking testbench for the schoolbook polynomial multiplier top level.
`timescale 1ns / 1ps

module polynomial_multiply_schoolbook_tb;
  import psm_pkg::*;

  localparam int MAX_TERMS     = 16;
  localparam int ACC_SLOTS     = 2 * MAX_TERMS - 1;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * ACC_SLOTS;
  localparam int PHASE_ITEMS   = 80;
  localparam int RANDOM_FILL   = 65536;

  typedef struct {
    in_item_t    item;
    int unsigned idle_pct;
  } term_request_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  term_request_t pending_terms[$];
  out_item_t     expected_products[$];

  // predictor state
  coef_t  a_store[MAX_TERMS];
  int     a_count;
  int     b_count;
  longint partial_sums[ACC_SLOTS];
  bit     b_open;

  int error_count;
  int terms_taken;
  int products_done;
  int coefs_checked;
  int quiet_cycles;

  polynomial_multiply_schoolbook #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_product();
    foreach (a_store[i]) a_store[i] = '0;
    foreach (partial_sums[i]) partial_sums[i] = 0;
    a_count = 0;
    b_count = 0;
    b_open  = 1'b0;
  endfunction

  // Fold one accepted coefficient into the running convolution.
  function automatic void convolve_term(input in_item_t it);
    int n;
    out_item_t r;
    if (it.operand_select == OPS_A) begin
      if (b_open) clear_product();
      if (a_count < MAX_TERMS) begin
        a_store[a_count] = it.coefficient;
        a_count++;
      end
      if (it.last_term) b_open = 1'b1;
    end else if (a_count != 0) begin
      b_open = 1'b1;
      if (b_count < MAX_TERMS) begin
        for (int i = 0; i < a_count; i++)
          partial_sums[i + b_count] += longint'(a_store[i]) * longint'(it.coefficient);
        b_count++;
      end
      if (it.last_term) begin
        n = a_count + b_count - 1;
        if (n > ACC_SLOTS) n = ACC_SLOTS;
        for (int i = 0; i < n; i++) begin
          r.product_coefficient = acc_t'(partial_sums[i]);
          r.last_result         = (i == n - 1);
          expected_products.push_back(r);
        end
        products_done++;
        clear_product();
      end
    end
  endfunction

  function automatic coef_t pick_coefficient();
    case ($urandom_range(7))
      0:       return coef_t'(-32768);
      1:       return coef_t'(32767);
      2:       return '0;
      3:       return coef_t'(-1);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Mostly short polynomials; now and then one near, at or past the size limit.
  function automatic int pick_length();
    if ($urandom_range(9) == 0) return $urandom_range(MAX_TERMS - 2, MAX_TERMS + 2);
    return $urandom_range(1, 6);
  endfunction

  function automatic void queue_term(input logic sel, input coef_t c, input logic last,
                                     input int unsigned pct);
    term_request_t t;
    t.item.operand_select = sel;
    t.item.coefficient    = c;
    t.item.last_term      = last;
    t.idle_pct            = pct;
    pending_terms.push_back(t);
  endfunction

  function automatic void queue_polynomial(input logic sel, input int len, input bit closed,
                                           input int fill, input int unsigned pct);
    coef_t c;
    for (int i = 0; i < len; i++) begin
      c = (fill == RANDOM_FILL) ? pick_coefficient() : coef_t'(fill);
      queue_term(sel, c, closed && (i == len - 1), pct);
    end
  endfunction

  // Driver: hold an item until taken, then advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else if (!start || !busy) begin
      if (pending_terms.size() != 0 &&
          $urandom_range(99) >= pending_terms[0].idle_pct) begin
        start   <= 1'b1;
        in_item <= pending_terms.pop_front().item;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check strobed results, then predict from the item taken this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result coef=%0d last=%0b", $time,
                   out_item.product_coefficient, out_item.last_result);
          error_count++;
        end else begin
          out_item_t exp_r;
          exp_r = expected_products.pop_front();
          coefs_checked++;
          if (out_item.product_coefficient !== exp_r.product_coefficient) begin
            $display("%0t: product_coefficient mismatch expected %0d actual %0d", $time,
                     exp_r.product_coefficient, out_item.product_coefficient);
            error_count++;
          end
          if (out_item.last_result !== exp_r.last_result) begin
            $display("%0t: last_result mismatch expected %0b actual %0b", $time,
                     exp_r.last_result, out_item.last_result);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        terms_taken++;
        convolve_term(in_item);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d items queued, %0d results pending", $time,
               pending_terms.size(), expected_products.size());
      $display("polynomial_multiply_schoolbook verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_idle[4] = '{0, 82, 0, 9};
    int phase_base;
    int fill;
    clear_product();
    error_count   = 0;
    terms_taken   = 0;
    products_done = 0;
    coefs_checked = 0;
    quiet_cycles  = 0;

    // B with nothing stored: ignored
    queue_term(OPS_B, coef_t'(5), 1'b1, 0);
    // single-term extremes
    queue_term(OPS_A, coef_t'(32767), 1'b1, 0);
    queue_term(OPS_B, coef_t'(-32768), 1'b1, 0);
    queue_term(OPS_A, coef_t'(-32768), 1'b1, 0);
    queue_term(OPS_B, coef_t'(-32768), 1'b1, 0);
    // B arrives while A is still open: A closes at one term
    queue_term(OPS_A, coef_t'(5), 1'b0, 0);
    queue_term(OPS_B, coef_t'(-1), 1'b1, 0);
    // new A while B loads: drop the pending product and restart
    queue_term(OPS_A, coef_t'(3), 1'b1, 0);
    queue_term(OPS_B, coef_t'(7), 1'b0, 0);
    queue_term(OPS_A, coef_t'(1), 1'b0, 0);
    queue_term(OPS_A, coef_t'(2), 1'b1, 0);
    queue_term(OPS_B, coef_t'(4), 1'b1, 0);
    // mixed signs and a zero term
    queue_term(OPS_A, coef_t'(-1), 1'b1, 0);
    queue_term(OPS_B, '0, 1'b0, 0);
    queue_term(OPS_B, coef_t'(32767), 1'b0, 0);
    queue_term(OPS_B, coef_t'(-32768), 1'b1, 0);

    foreach (phase_idle[p]) begin
      phase_base = pending_terms.size();
      while (pending_terms.size() - phase_base < PHASE_ITEMS) begin
        case ($urandom_range(19))
          0: queue_term(logic'($urandom_range(1)), coef_t'($urandom),
                        logic'($urandom_range(1)), phase_idle[p]);
          1: begin
            queue_polynomial(OPS_A, pick_length(), 1'b0, RANDOM_FILL, phase_idle[p]);
            queue_polynomial(OPS_B, pick_length(), 1'b1, RANDOM_FILL, phase_idle[p]);
          end
          2: begin
            queue_polynomial(OPS_A, pick_length(), 1'b1, RANDOM_FILL, phase_idle[p]);
            queue_polynomial(OPS_B, $urandom_range(1, 3), 1'b0, RANDOM_FILL,
                             phase_idle[p]);
          end
          3: begin
            // full-size operands with one extreme value everywhere
            fill = $urandom_range(1) ? 32767 : -32768;
            queue_polynomial(OPS_A, MAX_TERMS, 1'b1, fill, phase_idle[p]);
            queue_polynomial(OPS_B, MAX_TERMS, 1'b1, fill, phase_idle[p]);
          end
          default: begin
            queue_polynomial(OPS_A, pick_length(), 1'b1, RANDOM_FILL, phase_idle[p]);
            queue_polynomial(OPS_B, pick_length(), 1'b1, RANDOM_FILL, phase_idle[p]);
          end
        endcase
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_terms.size() != 0 || start || expected_products.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_products.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_products.size());
      error_count++;
    end
    $display("Took %0d coefficient items over four pacing phases.", terms_taken);
    $display("Completed %0d products, %0d product coefficients compared, %0d errors.",
             products_done, coefs_checked, error_count);
    if (error_count == 0) begin
      $display("polynomial_multiply_schoolbook verification clean");
    end else begin
      $display("polynomial_multiply_schoolbook verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/psm_pkg.sv
design/psm_cell.sv
design/polynomial_multiply_schoolbook.sv
dv/polynomial_multiply_schoolbook_tb.sv
